// ----- hw/rtl/ground_profile_interpolator_macros.svh -----
// Assertion helpers shared by the interpolator RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef GROUND_PROFILE_INTERPOLATOR_MACROS_SVH
`define GROUND_PROFILE_INTERPOLATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every edge.
`define GPI_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("%m: check failed");

// Consequent holds in the same cycle as the antecedent.
`define GPI_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent holds in the cycle after the antecedent.
`define GPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define GPI_ASSERT_ALWAYS(label, cond)
`define GPI_ASSERT_IMPLIES(label, ante, cons)
`define GPI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hw/rtl/gpi_pkg.sv -----
`timescale 1ns / 1ps

package gpi_pkg;

  // Field widths
  localparam int COORD_W        = 32;
  localparam int TOL_W          = 16;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 3;
  localparam int SEG_W          = 6;

  // Defaults and sizes
  localparam int MAX_POINTS_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;

  // Configuration port
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIDE_LEFT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_TOL = CFG_ADDR_W'(1);
  localparam logic [TOL_W-1:0]      TOL_RESET     = TOL_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_BEFORE  = 3'd0,
    ST_BEYOND  = 3'd1,
    ST_INTERP  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_STORED  = 3'd4,
    ST_FULL    = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [COORD_W-1:0] elevation;
    logic [SEG_W-1:0]          segment_index;
  } out_item_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    op_e                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } work_item_t;

endpackage

// ----- hw/rtl/gpi_ram.sv -----
`timescale 1ns / 1ps

module gpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gpi_front.sv -----
`timescale 1ns / 1ps

module gpi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  gpi_pkg::in_item_t   in_item_i,
  output logic                deq_valid_o,
  input  logic                deq_i,
  output gpi_pkg::work_item_t deq_item_o
);

  localparam int QD   = gpi_pkg::QUEUE_DEPTH;
  localparam int PTRW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNTW = $clog2(QD + 1);

  gpi_pkg::work_item_t fifo_q [QD];
  gpi_pkg::work_item_t item_cls;
  logic [PTRW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  // Classify the command; the unassigned code acts as a query
  always_comb begin
    item_cls.x = in_item_i.coord_x;
    item_cls.y = in_item_i.coord_y;
    unique case (gpi_pkg::cmd_e'(in_item_i.command))
      gpi_pkg::CMD_CLEAR:  item_cls.op = gpi_pkg::OP_CLEAR;
      gpi_pkg::CMD_APPEND: item_cls.op = gpi_pkg::OP_APPEND;
      default:             item_cls.op = gpi_pkg::OP_QUERY;
    endcase
  end

  assign full_o      = (cnt_q == CNTW'(QD));
  assign deq_valid_o = (cnt_q != '0);
  assign deq_item_o  = fifo_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = deq_i && deq_valid_o;

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTRW'(QD - 1)) ? '0 : wptr_q + PTRW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTRW'(QD - 1)) ? '0 : rptr_q + PTRW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wptr_q] <= item_cls;
    end
  end

endmodule

// ----- hw/rtl/gpi_muldiv.sv -----
`timescale 1ns / 1ps

module gpi_muldiv (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [gpi_pkg::COORD_W:0]            mag_a_i,
  input  logic [gpi_pkg::COORD_W:0]            mag_b_i,
  input  logic [gpi_pkg::COORD_W:0]            mag_d_i,
  output logic                                 done_o,
  output logic [2*gpi_pkg::COORD_W+1:0]        quot_o
);

  localparam int W    = gpi_pkg::COORD_W;
  localparam int PW   = 2 * W + 2;
  localparam int CNTW = $clog2(PW);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e        state_q, state_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [PW-1:0]    p_q, p_d;
  logic [W:0]       b_q, b_d, d_q, d_d, r_q, r_d;
  logic [W+1:0]     mul_sum, rem_sh, rem_sub;
  logic             rem_ge;

  // One multiplier bit per cycle: add into the high half, shift right
  assign mul_sum = {1'b0, p_q[PW-1:W+1]} + (p_q[0] ? {1'b0, b_q} : '0);

  // One quotient bit per cycle: restoring step
  assign rem_sh  = {r_q, p_q[PW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, d_q});
  assign rem_sub = rem_sh - {1'b0, d_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    p_d     = p_q;
    b_d     = b_q;
    d_d     = d_q;
    r_d     = r_q;
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          p_d     = {(W + 1)'(0), mag_a_i};
          b_d     = mag_b_i;
          d_d     = mag_d_i;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        p_d   = {mul_sum, p_q[W:1]};
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(W)) begin
          cnt_d   = '0;
          r_d     = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        r_d   = rem_ge ? rem_sub[W:0] : rem_sh[W:0];
        p_d   = {p_q[PW-2:0], rem_ge};
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(PW - 1)) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    b_q <= b_d;
    d_q <= d_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign quot_o = p_q;

endmodule

// ----- hw/rtl/gpi_back.sv -----
`timescale 1ns / 1ps
`include "ground_profile_interpolator_macros.svh"

module gpi_back #(
  parameter int MAX_POINTS = gpi_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          side_left_i,
  input  logic [gpi_pkg::TOL_W-1:0]     tol_i,
  input  logic                          deq_valid_i,
  output logic                          deq_o,
  input  gpi_pkg::work_item_t           item_i,
  output logic                          out_valid_o,
  input  logic                          pop_i,
  output gpi_pkg::out_item_t            out_item_o
);

  localparam int W    = gpi_pkg::COORD_W;
  localparam int IDXW = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int EXTW = CNTW + gpi_pkg::SEG_W;
  localparam logic [2*W+1:0] CAP = (2 * W + 2)'(1) << (W + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WALK = 7'b0000010,
    S_LAST = 7'b0000100,
    S_RD0  = 7'b0001000,
    S_RD1  = 7'b0010000,
    S_MD   = 7'b0100000,
    S_EMIT = 7'b1000000
  } back_state_e;

  back_state_e              state_q, state_d;
  logic [CNTW-1:0]          count_q, count_d, idx_q, idx_d;
  logic                     out_valid_q, out_valid_d;
  gpi_pkg::out_item_t       out_q, out_d, pend_q, pend_d;
  logic signed [W-1:0]      qx_q, qx_d, x0_q, x0_d, y0_q, y0_d;
  logic                     neg_q, neg_d;
  logic                     slot_free;

  // Point stores
  logic                     we;
  logic [IDXW-1:0]          waddr, x_raddr, y_raddr;
  logic [W-1:0]             x_rd_raw, y_rd_raw;
  logic signed [W-1:0]      x_rd, y_rd;

  // Walk compare and interpolation datapath
  logic [CNTW-1:0]          idx_inc, idx_dec, cnt_dec;
  logic signed [W+1:0]      qx_ext, px_ext, tol_ext;
  logic                     adv;
  logic signed [W:0]        dx, dy, num;
  logic [W:0]               mag_dx, mag_dy, mag_num;
  logic                     md_start, md_done;
  logic [2*W+1:0]           md_quot;
  logic [W+1:0]             qc;
  logic signed [W+2:0]      elev_sum;
  logic [3:0]               elev_top;
  logic signed [W-1:0]      elev_sat;

  function automatic logic [gpi_pkg::SEG_W-1:0] seg_of(input logic [CNTW-1:0] v);
    logic [EXTW-1:0] ext;
    ext = EXTW'(v);
    return ext[gpi_pkg::SEG_W-1:0];
  endfunction

  gpi_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_i.x),
    .raddr_i (x_raddr),
    .rdata_o (x_rd_raw)
  );

  gpi_ram #(.WIDTH(W), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_i.y),
    .raddr_i (y_raddr),
    .rdata_o (y_rd_raw)
  );

  gpi_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mag_a_i (mag_num),
    .mag_b_i (mag_dy),
    .mag_d_i (mag_dx),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  assign x_rd    = x_rd_raw;
  assign y_rd    = y_rd_raw;
  assign waddr   = count_q[IDXW-1:0];
  assign idx_inc = idx_q + CNTW'(1);
  assign idx_dec = idx_q - CNTW'(1);
  assign cnt_dec = count_q - CNTW'(1);

  // Advance test against the point just read
  assign qx_ext  = (W + 2)'(qx_q);
  assign px_ext  = (W + 2)'(x_rd);
  assign tol_ext = $signed((W + 2)'(tol_i));
  assign adv     = side_left_i ? (qx_ext < px_ext - tol_ext) : (qx_ext > px_ext + tol_ext);

  // Segment deltas, sign and magnitudes
  assign dx      = (W + 1)'(x_rd) - (W + 1)'(x0_q);
  assign dy      = (W + 1)'(y_rd) - (W + 1)'(y0_q);
  assign num     = (W + 1)'(qx_q) - (W + 1)'(x0_q);
  assign mag_dx  = dx[W]  ? (W + 1)'(-dx)  : (W + 1)'(dx);
  assign mag_dy  = dy[W]  ? (W + 1)'(-dy)  : (W + 1)'(dy);
  assign mag_num = num[W] ? (W + 1)'(-num) : (W + 1)'(num);

  // Clamp the quotient, apply the sign, saturate the sum
  assign qc       = (md_quot > CAP) ? CAP[W+1:0] : md_quot[W+1:0];
  assign elev_sum = neg_q ? (W + 3)'(y0_q) - $signed({1'b0, qc})
                          : (W + 3)'(y0_q) + $signed({1'b0, qc});
  assign elev_top = elev_sum[W+2:W-1];
  always_comb begin
    if (elev_top == 4'b0000 || elev_top == 4'b1111) begin
      elev_sat = elev_sum[W-1:0];
    end else if (elev_sum[W+2]) begin
      elev_sat = {1'b1, (W - 1)'(0)};
    end else begin
      elev_sat = {1'b0, {(W - 1){1'b1}}};
    end
  end

  assign slot_free = !out_valid_q || pop_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    qx_d        = qx_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    neg_d       = neg_q;
    deq_o       = 1'b0;
    we          = 1'b0;
    x_raddr     = '0;
    y_raddr     = '0;
    md_start    = 1'b0;

    if (pop_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (deq_valid_i) begin
          deq_o                = 1'b1;
          qx_d                 = item_i.x;
          pend_d.elevation     = '0;
          pend_d.segment_index = '0;
          state_d              = S_EMIT;
          unique case (item_i.op)
            gpi_pkg::OP_CLEAR: begin
              count_d       = '0;
              pend_d.status = gpi_pkg::ST_CLEARED;
            end
            gpi_pkg::OP_APPEND: begin
              if (count_q < CNTW'(MAX_POINTS)) begin
                we                   = 1'b1;
                count_d              = count_q + CNTW'(1);
                pend_d.status        = gpi_pkg::ST_STORED;
                pend_d.segment_index = seg_of(count_q);
              end else begin
                pend_d.status        = gpi_pkg::ST_FULL;
                pend_d.segment_index = seg_of(CNTW'(MAX_POINTS - 1));
              end
            end
            default: begin
              if (count_q == '0) begin
                pend_d.status = gpi_pkg::ST_EMPTY;
              end else begin
                idx_d   = '0;
                x_raddr = '0;
                state_d = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        // Check the index first so no entry past the table is compared
        if (idx_q == count_q) begin
          y_raddr              = cnt_dec[IDXW-1:0];
          pend_d.status        = gpi_pkg::ST_BEYOND;
          pend_d.segment_index = seg_of(cnt_dec);
          state_d              = S_LAST;
        end else if (adv) begin
          idx_d   = idx_inc;
          x_raddr = idx_inc[IDXW-1:0];
        end else if (idx_q == '0) begin
          y_raddr              = '0;
          pend_d.status        = gpi_pkg::ST_BEFORE;
          pend_d.segment_index = '0;
          state_d              = S_LAST;
        end else begin
          x_raddr = idx_dec[IDXW-1:0];
          y_raddr = idx_dec[IDXW-1:0];
          state_d = S_RD0;
        end
      end
      S_LAST: begin
        pend_d.elevation = y_rd;
        state_d          = S_EMIT;
      end
      S_RD0: begin
        x0_d    = x_rd;
        y0_d    = y_rd;
        x_raddr = idx_q[IDXW-1:0];
        y_raddr = idx_q[IDXW-1:0];
        state_d = S_RD1;
      end
      S_RD1: begin
        pend_d.status        = gpi_pkg::ST_INTERP;
        pend_d.segment_index = seg_of(idx_q);
        if (dx == '0) begin
          pend_d.elevation = y0_q;
          state_d          = S_EMIT;
        end else begin
          md_start = 1'b1;
          neg_d    = num[W] ^ dy[W] ^ dx[W];
          state_d  = S_MD;
        end
      end
      S_MD: begin
        if (md_done) begin
          pend_d.elevation = elev_sat;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
    qx_q   <= qx_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    neg_q  <= neg_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `GPI_ASSERT_ALWAYS(a_count_bound, count_q <= CNTW'(MAX_POINTS))
  `GPI_ASSERT_IMPLIES(a_walk_in_table, state_q == S_WALK, idx_q <= count_q)
  `GPI_ASSERT_IMPLIES(a_md_done_in_md, md_done, state_q == S_MD)
  `GPI_ASSERT_NEXT(a_emit_loads_out, state_q == S_EMIT && slot_free, out_valid_q)

endmodule

// ----- hw/rtl/ground_profile_interpolator.sv -----
`timescale 1ns / 1ps

// Ground profile interpolator: holds up to MAX_POINTS breakpoints (x offset, elevation,
// signed Q19.13) and answers clear, append and query items in arrival order, one result
// per item. Items enter a two-entry queue. The back end executes them one at a time and
// takes the oldest queued item whenever it is idle. A clear or append takes the item,
// then loads the output register. A query first takes the item. It then walks the
// stored x values one per cycle from the first point. Before the first point or past
// the last point, it reads one elevation and loads the output register. Inside a
// segment, it reads both end points, then runs the serial multiply-divide unit, one bit
// per cycle, which multiplies and then divides. A zero-width segment skips the unit. A
// result waits in the output register until it is popped, and the back end holds the
// next result until the register is free. The serial unit and the single read port of
// each point store set the pace of a query. Configuration (side and tolerance) is
// written through its own port; the user must write it only while no item is in
// flight, as the block itself does not enforce this; its ready is always high.
module ground_profile_interpolator #(
  parameter int MAX_POINTS = gpi_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  gpi_pkg::in_item_t                 in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output gpi_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gpi_pkg::CFG_ADDR_W-1:0]    cfg_index_i,
  input  logic [gpi_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic                        side_left_q, side_left_d;
  logic [gpi_pkg::TOL_W-1:0]   tol_q, tol_d;
  logic                        deq_valid, deq, out_valid;
  gpi_pkg::work_item_t         work_item;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    side_left_d = side_left_q;
    tol_d       = tol_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gpi_pkg::CFG_SIDE_LEFT: side_left_d = cfg_data_i[0];
        gpi_pkg::CFG_MATCH_TOL: tol_d       = cfg_data_i[gpi_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_left_q <= 1'b0;
      tol_q       <= gpi_pkg::TOL_RESET;
    end else begin
      side_left_q <= side_left_d;
      tol_q       <= tol_d;
    end
  end

  gpi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_item_i   (in_item_i),
    .deq_valid_o (deq_valid),
    .deq_i       (deq),
    .deq_item_o  (work_item)
  );

  gpi_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .side_left_i (side_left_q),
    .tol_i       (tol_q),
    .deq_valid_i (deq_valid),
    .deq_o       (deq),
    .item_i      (work_item),
    .out_valid_o (out_valid),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

  assign empty = !out_valid;

endmodule
